// File: sv/assert_macros.svh
// Assertion macros shared by the load balancer selector RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// File: sv/blsel_pkg.sv
// Package for the load balancer selector: types, codes, reset values.
// No dependencies.
`default_nettype none
package blsel_pkg;
  localparam int NUM_BACKENDS_DEF  = 8;
  localparam int ROTATION_BITS_DEF = 32;
  localparam int ACTIVE_BITS_DEF   = 16;

  typedef enum logic [2:0] {
    CMD_PICK = 3'd0, CMD_ACQUIRE = 3'd1, CMD_RELEASE = 3'd2,
    CMD_PROBE = 3'd3, CMD_ADMIN = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    H_HEALTHY = 2'd0, H_DEGRADED = 2'd1, H_DOWN = 2'd2
  } health_t;

  typedef enum logic [1:0] {
    STRAT_LEAST = 2'd0, STRAT_RR = 2'd1, STRAT_WRR = 2'd2, STRAT_HASH = 2'd3
  } strat_t;

  typedef enum logic [2:0] {
    REG_STRATEGY = 3'd0, REG_MAX_FAIL = 3'd1, REG_BACKUP = 3'd2,
    REG_WEIGHTS = 3'd3, REG_COUNT = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DIV_START, S_DIV_WAIT, S_SELECT, S_LEAST, S_WALK,
    S_UPDATE, S_OUT
  } state_t;

  // Divider handshake.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  localparam logic [63:0] WEIGHTS_RESET = 64'h0101010101010101;
endpackage
`default_nettype wire

// File: sv/blsel_div.sv
// Iterative restoring divider, one quotient bit per cycle; remainder only.
// Depends on blsel_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module blsel_div import blsel_pkg::*; #(
  parameter int W = ROTATION_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire div_ctl_t     ctl,
  input  wire logic [W-1:0] dividend,
  input  wire logic [11:0]  divisor,
  output div_sts_t          sts,
  output logic [11:0]       remainder
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [12:0]   rem_r, rem_nxt;
  logic [11:0]  dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [12:0]   shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[11:0], quo_r[W-1]};
    if (ctl.start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[W-2:0], 1'b0};
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = shifted - {1'b0, dsr_r};
      end else begin
        rem_nxt = shifted;
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign remainder = rem_r[11:0];

  `CHK_IMPL(a_div_done_idle, clk, rst_n, done_r, !busy_r)
  `CHK_NEXT(a_div_start_busy, clk, rst_n, ctl.start, busy_r)
  `CHK_IMPL(a_div_rem_lt, clk, rst_n, done_r && dsr_r != 12'd0, rem_r < {1'b0, dsr_r})
endmodule
`default_nettype wire

// File: sv/backend_load_balancer_selector_top.sv
// Load balancer selector: one command beat in, one result beat out.
// Checks the backend table and picks backends by the configured strategy.
// Channels: in_* carries a command (pick, acquire, release, probe, admin);
// out_* returns found/chosen plus health, active and fail counts of the
// chosen or addressed backend. cfg_* writes the five registers by index.
// Non-pick commands pass through S_UPDATE, which updates the addressed backend
// if it is in use, and then S_OUT. Picks scan the backends in use one per
// cycle, twice when no primary is alive. Round robin, weighted round robin
// (when its total weight is nonzero) and ip hash then run the shared
// divider, DW bits wide, DW being ROTATION_BITS but at least 32. Least
// connections then compares the candidates' active counts, weighted round
// robin walks the candidates by weight, round robin and ip hash take the
// candidate at the remainder; S_OUT then loads the result.
// One item is in work at a time; in_ready is low from accept until the
// result is loaded into the output register. That register holds its beat
// while out_ready is low, and a finished item waits until the beat is taken.
// Reset (rst_n low, synchronous) sets all backends healthy with zero counts,
// clears the rotation counter and loads the register reset values.
// Configure only while idle.
`default_nettype none
`include "assert_macros.svh"
module backend_load_balancer_selector_top import blsel_pkg::*; #(
  parameter int NUM_BACKENDS  = NUM_BACKENDS_DEF,
  parameter int ROTATION_BITS = ROTATION_BITS_DEF,
  parameter int ACTIVE_BITS   = ACTIVE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [2:0]  in_backend,
  input  wire logic        in_ok,
  input  wire logic        in_enable,
  input  wire logic [31:0] in_client_hash,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [2:0]       out_chosen,
  output logic [1:0]       out_health,
  output logic [15:0]      out_active_now,
  output logic [7:0]       out_fails_now,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam int NB  = NUM_BACKENDS;
  localparam int IW  = (NB > 1) ? $clog2(NB) : 1;
  localparam int NW  = $clog2(NB + 1);
  localparam int DW  = (ROTATION_BITS > 32) ? ROTATION_BITS : 32;
  localparam logic [ACTIVE_BITS-1:0] AMAX = '1;

  // configuration
  logic [1:0]  strategy_r;
  logic [7:0]  max_fail_r, backup_r;
  logic [63:0] weights_r;
  logic [3:0]  count_r;

  // backend table
  health_t              health_r [NB];
  logic [7:0]           fails_r  [NB];
  logic [ACTIVE_BITS-1:0] active_r [NB];
  logic [ROTATION_BITS-1:0] rot_r, rot_nxt;

  // item registers
  logic [2:0]  cmd_r;
  logic [2:0]  bk_r;
  logic        ok_r, en_r;
  logic [31:0] hash_r;

  state_t      state_r, state_nxt;
  logic [IW-1:0] cand_r [NB];
  logic [IW-1:0] cand_nxt [NB];
  logic [NW-1:0] n_r, n_nxt;
  logic [IW:0]   i_r, i_nxt;
  logic          pass_r, pass_nxt;
  logic [11:0]   total_r, total_nxt;
  logic [11:0]   slot_r, slot_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic          found_r, found_nxt;

  logic          ov_r, ov_nxt;
  logic          o_found_r, o_found_nxt;
  logic [2:0]    o_chosen_r, o_chosen_nxt;
  logic [1:0]    o_health_r, o_health_nxt;
  logic [15:0]   o_active_r, o_active_nxt;
  logic [7:0]    o_fails_r, o_fails_nxt;

  div_ctl_t      dctl;
  div_sts_t      dsts;
  logic [DW-1:0] dividend;
  logic [11:0]   divisor;
  logic [11:0]   drem;

  logic [3:0]    lim;
  logic [IW-1:0] scan_idx, cand_i;
  logic [7:0]    w_i;
  logic [IW-1:0] bsel;
  logic          bvalid, bactive;

  // table write request from the sequencer
  logic          tw_en;
  health_t       tw_health;
  logic [7:0]    tw_fails;
  logic [ACTIVE_BITS-1:0] tw_active;
  logic [8:0]    fail_inc;

  always_comb begin
    lim = count_r;
    if (lim == 4'd0) lim = 4'd1;
    if ({28'd0, lim} > NB) lim = 4'(NB);
  end

  assign scan_idx = i_r[IW-1:0];
  assign cand_i   = cand_r[i_r[IW-1:0]];
  assign w_i      = weights_r[{cand_i, 3'b000} +: 8];
  assign bvalid   = {29'd0, bk_r} < NB;
  assign bactive  = {1'b0, bk_r} < lim;
  assign bsel     = bk_r[IW-1:0];

  blsel_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(dividend),
    .divisor(divisor), .sts(dsts), .remainder(drem)
  );

  always_comb begin
    state_nxt = state_r;
    for (int k = 0; k < NB; k++) cand_nxt[k] = cand_r[k];
    n_nxt = n_r; i_nxt = i_r; pass_nxt = pass_r;
    total_nxt = total_r; slot_nxt = slot_r;
    pick_nxt = pick_r; found_nxt = found_r; rot_nxt = rot_r;
    ov_nxt = ov_r;
    o_found_nxt = o_found_r; o_chosen_nxt = o_chosen_r;
    o_health_nxt = o_health_r; o_active_nxt = o_active_r; o_fails_nxt = o_fails_r;
    dctl.start = 1'b0;
    dividend = '0;
    divisor = 12'd1;
    tw_en = 1'b0;
    tw_health = health_r[bsel];
    tw_fails = fails_r[bsel];
    tw_active = active_r[bsel];
    fail_inc = {1'b0, fails_r[bsel]} + 9'd1;
    in_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (strategy_r == STRAT_HASH) begin
      dividend = DW'(hash_r);
      divisor = {{(12-NW){1'b0}}, n_r};
    end else if (strategy_r == STRAT_RR) begin
      dividend = DW'(rot_r);
      divisor = {{(12-NW){1'b0}}, n_r};
    end else begin
      dividend = DW'(rot_r);
      divisor = total_r;
    end
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          i_nxt = '0; n_nxt = '0; pass_nxt = 1'b0; total_nxt = '0;
          found_nxt = 1'b0; pick_nxt = '0;
          state_nxt = (in_cmd == CMD_PICK) ? S_SCAN : S_UPDATE;
        end
      end
      S_SCAN: begin
        if (int'(i_r) < int'(lim)) begin
          if (health_r[scan_idx] != H_DOWN && backup_r[scan_idx] == pass_r) begin
            cand_nxt[n_r[IW-1:0]] = scan_idx;
            n_nxt = n_r + NW'(1);
            total_nxt = total_r + {4'd0, weights_r[{scan_idx, 3'b000} +: 8]};
          end
          i_nxt = i_r + (IW+1)'(1);
        end else if (n_r == '0 && !pass_r) begin
          pass_nxt = 1'b1;
          i_nxt = '0;
        end else if (n_r == '0) begin
          found_nxt = 1'b0;
          state_nxt = S_OUT;
        end else begin
          found_nxt = 1'b1;
          pick_nxt = cand_r[0];
          i_nxt = (IW+1)'(1);
          case (strategy_r)
            STRAT_LEAST: state_nxt = S_LEAST;
            STRAT_WRR:   state_nxt = (total_r == 12'd0) ? S_OUT : S_DIV_START;
            default:     state_nxt = S_DIV_START;
          endcase
        end
      end
      S_DIV_START: begin
        dctl.start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (dsts.done) begin
          slot_nxt = drem;
          i_nxt = '0;
          if (strategy_r != STRAT_HASH) rot_nxt = rot_r + ROTATION_BITS'(1);
          state_nxt = (strategy_r == STRAT_WRR) ? S_WALK : S_SELECT;
        end
      end
      S_SELECT: begin
        pick_nxt = cand_r[slot_r[IW-1:0]];
        state_nxt = S_OUT;
      end
      S_LEAST: begin
        if (int'(i_r) < int'(n_r)) begin
          if (active_r[cand_i] < active_r[pick_r]) pick_nxt = cand_i;
          i_nxt = i_r + (IW+1)'(1);
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_WALK: begin
        if (slot_r < {4'd0, w_i} || int'(i_r) + 1 >= int'(n_r)) begin
          pick_nxt = cand_i;
          state_nxt = S_OUT;
        end else begin
          slot_nxt = slot_r - {4'd0, w_i};
          i_nxt = i_r + (IW+1)'(1);
        end
      end
      S_UPDATE: begin
        if (bvalid && bactive) begin
          tw_en = 1'b1;
          case (cmd_r)
            CMD_ACQUIRE: begin
              if (ok_r) begin
                if (active_r[bsel] != AMAX) tw_active = active_r[bsel] + ACTIVE_BITS'(1);
              end else begin
                tw_fails = fail_inc[8] ? 8'hFF : fail_inc[7:0];
                tw_health = (tw_fails >= max_fail_r) ? H_DOWN : H_DEGRADED;
              end
            end
            CMD_RELEASE: begin
              if (active_r[bsel] != '0) tw_active = active_r[bsel] - ACTIVE_BITS'(1);
              if (!ok_r) begin
                tw_fails = fail_inc[8] ? 8'hFF : fail_inc[7:0];
                tw_health = (tw_fails >= max_fail_r) ? H_DOWN : H_DEGRADED;
              end
            end
            CMD_PROBE: begin
              if (ok_r) begin
                tw_fails = 8'd0;
                tw_health = H_HEALTHY;
              end else begin
                tw_fails = fail_inc[8] ? 8'hFF : fail_inc[7:0];
                tw_health = (tw_fails >= max_fail_r) ? H_DOWN : H_DEGRADED;
              end
            end
            CMD_ADMIN: tw_health = en_r ? H_HEALTHY : H_DOWN;
            default: tw_en = 1'b0;
          endcase
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          if (cmd_r == CMD_PICK) begin
            o_found_nxt = found_r;
            o_chosen_nxt = found_r ? 3'(pick_r) : 3'd0;
            o_health_nxt = found_r ? health_r[pick_r] : 2'd0;
            o_active_nxt = found_r ? 16'(active_r[pick_r]) : 16'd0;
            o_fails_nxt = found_r ? fails_r[pick_r] : 8'd0;
          end else begin
            o_found_nxt = 1'b0;
            o_chosen_nxt = 3'd0;
            if (bvalid && cmd_r <= CMD_ADMIN) begin
              o_health_nxt = health_r[bsel];
              o_active_nxt = 16'(active_r[bsel]);
              o_fails_nxt = fails_r[bsel];
            end else begin
              o_health_nxt = 2'd0; o_active_nxt = 16'd0; o_fails_nxt = 8'd0;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NB; k++) cand_r[k] <= cand_nxt[k];
    i_r <= i_nxt; pass_r <= pass_nxt; total_r <= total_nxt;
    slot_r <= slot_nxt; pick_r <= pick_nxt;
    o_found_r <= o_found_nxt; o_chosen_r <= o_chosen_nxt;
    o_health_r <= o_health_nxt; o_active_r <= o_active_nxt; o_fails_r <= o_fails_nxt;
    if (in_valid && in_ready) begin
      cmd_r <= in_cmd; bk_r <= in_backend; ok_r <= in_ok;
      en_r <= in_enable; hash_r <= in_client_hash;
    end
    if (!rst_n) begin
      n_r <= '0; found_r <= 1'b0; ov_r <= 1'b0; rot_r <= '0;
    end else begin
      n_r <= n_nxt; found_r <= found_nxt; ov_r <= ov_nxt; rot_r <= rot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NB; k++) begin
        health_r[k] <= H_HEALTHY;
        fails_r[k] <= 8'd0;
        active_r[k] <= '0;
      end
    end else if (tw_en) begin
      health_r[bsel] <= tw_health;
      fails_r[bsel] <= tw_fails;
      active_r[bsel] <= tw_active;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r <= STRAT_LEAST;
      max_fail_r <= 8'd3;
      backup_r <= 8'd0;
      weights_r <= WEIGHTS_RESET;
      count_r <= 4'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STRATEGY: strategy_r <= cfg_data[1:0];
        REG_MAX_FAIL: max_fail_r <= cfg_data[7:0];
        REG_BACKUP:   backup_r <= cfg_data[7:0];
        REG_WEIGHTS:  weights_r <= cfg_data;
        REG_COUNT:    count_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign out_valid      = ov_r;
  assign out_found      = o_found_r;
  assign out_chosen     = o_chosen_r;
  assign out_health     = o_health_r;
  assign out_active_now = o_active_r;
  assign out_fails_now  = o_fails_r;

  `CHK_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `CHK_IMPL(a_notfound_zero, clk, rst_n, ov_r && !o_found_r, o_chosen_r == 3'd0)
  `CHK_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule
`default_nettype wire
